[rtl/core/fsta_pkg.sv]
package fsta_pkg;

  localparam int unsigned TIME_BITS_DEF = 64;
  localparam int unsigned ELAPSED_W     = 64;
  localparam int unsigned PERIOD_W      = 32;
  localparam int unsigned LIMIT_W       = 32;
  localparam int unsigned WIDE_W        = 63;

  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = 32'd16666667;

  typedef enum logic {
    REQ_ADVANCE = 1'b0,
    REQ_DISCARD = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_NEG = 2'd1,
    ST_OVF = 2'd2
  } status_t;

  typedef struct packed {
    req_t                        req_type;
    logic signed [ELAPSED_W-1:0] elapsed_time;
    logic [LIMIT_W-1:0]          step_limit;
  } fsta_in_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] granted_steps;
    logic [WIDE_W-1:0]  backlog_steps;
    logic [WIDE_W-1:0]  remaining_time;
    logic               limit_reached;
    logic [WIDE_W-1:0]  discarded_time;
    status_t            status;
  } fsta_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_MIN,
    S_MUL,
    S_SUB,
    S_FINISH
  } fsta_state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic div_step;
    logic min_sel;
    logic mul;
    logic sub;
    logic commit;
  } fsta_cmd_t;

  typedef struct packed {
    logic chk_err;
  } fsta_sts_t;

endpackage

[rtl/core/fsta_dp.sv]
module fsta_dp
  import fsta_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fsta_in_t            in_data,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_data,
  input  fsta_cmd_t           cmd,
  output fsta_sts_t           sts,
  output fsta_out_t           out_data
);

  localparam int unsigned ACC_W = TIME_BITS - 1;

  logic [PERIOD_W-1:0]  cfg_period_r;
  logic [ACC_W-1:0]     acc_r;
  fsta_in_t             req_r;
  logic [PERIOD_W-1:0]  period_r;
  status_t              status_r;
  logic [ACC_W-1:0]     dividend_r;
  logic [ACC_W-1:0]     quo_r;
  logic [PERIOD_W-1:0]  rem_r;
  logic [LIMIT_W-1:0]   granted_r;
  logic [ACC_W-1:0]     pending_r;
  logic                 reached_r;
  logic [2*PERIOD_W-1:0] prod_r;
  logic [ACC_W-1:0]     new_acc_r;
  logic [ACC_W-1:0]     disc_r;
  fsta_out_t            out_r;

  logic [ELAPSED_W-1:0] sum;
  logic                 neg;
  logic                 ovf;
  status_t              chk_status;
  logic [PERIOD_W:0]    trial;
  logic                 ge;
  logic [PERIOD_W:0]    diff;
  logic [ELAPSED_W-1:0] quo_ext;
  logic [ELAPSED_W-1:0] lim_ext;
  logic [LIMIT_W-1:0]   granted_nxt;
  logic                 adv_ok;

  // A negative elapsed time is flagged on its own; otherwise both terms are below
  // 2^63, so this sum cannot wrap.
  assign sum = ELAPSED_W'(acc_r) + $unsigned(req_r.elapsed_time);
  assign neg = req_r.elapsed_time[ELAPSED_W-1];
  assign ovf = (sum >> ACC_W) != '0;

  always_comb begin
    chk_status = ST_OK;
    if (req_r.req_type == REQ_ADVANCE) begin
      if (neg) begin
        chk_status = ST_NEG;
      end else if (ovf) begin
        chk_status = ST_OVF;
      end
    end
  end

  assign sts.chk_err = (chk_status != ST_OK);

  // One restoring division step per cycle; the remainder stays below the period.
  assign trial = {rem_r, quo_r[ACC_W-1]};
  assign ge    = trial >= {1'b0, period_r};
  assign diff  = trial - {1'b0, period_r};

  assign quo_ext     = ELAPSED_W'(quo_r);
  assign lim_ext     = ELAPSED_W'(req_r.step_limit);
  assign granted_nxt = (quo_ext < lim_ext) ? quo_ext[LIMIT_W-1:0] : req_r.step_limit;

  assign adv_ok = (status_r == ST_OK) && (req_r.req_type == REQ_ADVANCE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_period_r <= STEP_PERIOD_RST;
      acc_r        <= '0;
    end else begin
      if (cfg_we) begin
        cfg_period_r <= cfg_data;
      end
      if (cmd.commit) begin
        acc_r <= new_acc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_data;
      period_r <= (cfg_period_r == '0) ? PERIOD_W'(1) : cfg_period_r;
    end
    if (cmd.check) begin
      status_r  <= chk_status;
      new_acc_r <= acc_r;
      rem_r     <= '0;
      if (req_r.req_type == REQ_ADVANCE) begin
        dividend_r <= sum[ACC_W-1:0];
        quo_r      <= sum[ACC_W-1:0];
      end else begin
        dividend_r <= acc_r;
        quo_r      <= acc_r;
      end
    end
    if (cmd.div_step) begin
      rem_r <= ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      quo_r <= {quo_r[ACC_W-2:0], ge};
    end
    if (cmd.min_sel) begin
      granted_r <= granted_nxt;
      pending_r <= quo_r - ACC_W'(granted_nxt);
      reached_r <= quo_ext > lim_ext;
    end
    if (cmd.mul) begin
      prod_r <= granted_r * period_r;
    end
    if (cmd.sub) begin
      if (req_r.req_type == REQ_DISCARD) begin
        new_acc_r <= ACC_W'(rem_r);
        disc_r    <= dividend_r - ACC_W'(rem_r);
      end else begin
        new_acc_r <= dividend_r - prod_r[ACC_W-1:0];
        disc_r    <= '0;
      end
    end
    if (cmd.commit) begin
      out_r.granted_steps  <= adv_ok ? granted_r : '0;
      out_r.backlog_steps  <= adv_ok ? WIDE_W'(pending_r) : '0;
      out_r.limit_reached  <= adv_ok & reached_r;
      out_r.remaining_time <= WIDE_W'(new_acc_r);
      out_r.discarded_time <= (req_r.req_type == REQ_DISCARD) ? WIDE_W'(disc_r) : '0;
      out_r.status         <= status_r;
    end
  end

  assign out_data = out_r;

endmodule

[rtl/core/fsta_ctrl.sv]
module fsta_ctrl
  import fsta_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  fsta_sts_t sts,
  output fsta_cmd_t cmd
);

  localparam int unsigned CNT_W = $clog2(TIME_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_BITS - 2);

  fsta_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.chk_err ? S_FINISH : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_MIN;
        end
      end
      S_MIN: begin
        cmd.min_sel = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // Hold the finished transaction until the output register is free.
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/core/fixed_step_time_accumulator.sv]
// Fixed-step time accumulator.
// Input channel (in_valid / in_stall / in_data): each transaction is either an
// advance by an elapsed time or a discard of all whole pending steps. Each one
// produces exactly one result transaction on out_valid / out_stall / out_data.
// Configuration channel (cfg_valid / cfg_ready / cfg_data) writes the step
// period; it is always ready and should be written only while the block is idle.
// A period of zero behaves as a period of one.
// Sequence: a taken request is checked, then a radix-2 divider that retires one
// quotient bit per cycle divides the time by the period; an advance's grant is
// picked against the step limit, multiplied by the period and subtracted, and
// the result is committed to the output register. Requests rejected for a
// negative elapsed time or a store overflow go from the check to the commit.
// One request is processed at a time; in_stall is low only while idle.
// A finished result sits in the output register while out_stall is high, and
// the next request is already taken and worked on meanwhile; it waits at its
// final step until the register frees up.
// Reset (rst_n low, synchronous) clears the accumulated time, restores the
// default step period and drops any transaction in flight.
module fixed_step_time_accumulator
  import fsta_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fsta_in_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fsta_out_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data
);

  fsta_cmd_t cmd;
  fsta_sts_t sts;

  assign cfg_ready = 1'b1;

  fsta_ctrl #(
    .TIME_BITS(TIME_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fsta_dp #(
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

  // Only one request may be in work at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in work");

  // A result is never written over one that is still waiting.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

  // The sequencer issues at most one datapath command per cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command active");

  // A rejected advance grants nothing.
  a_err_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |->
      (out_data.granted_steps == '0 && !out_data.limit_reached))
    else $error("steps granted on a rejected request");

endmodule

[dv/fsta_step_checker.sv]
`timescale 1ns / 1ps

module fsta_step_checker
  import fsta_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  fsta_in_t            in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  fsta_out_t           out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data,
  output int                  mismatches,
  output int                  results_owed
);

  localparam logic [63:0] STORE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  logic [PERIOD_W-1:0] period_reg;
  logic [63:0]         stored_time;
  fsta_out_t           step_reports_due[$];
  fsta_out_t           want;

  initial mismatches = 0;

  // Updates the mirrored store and returns the report that one request must produce.
  function automatic fsta_out_t accumulate_request(fsta_in_t req);
    fsta_out_t   res;
    logic [63:0] period;
    logic [63:0] elapsed;
    logic [63:0] limit;
    logic [63:0] avail;
    logic [63:0] granted;
    res     = '0;
    period  = (period_reg == '0) ? 64'd1 : 64'(period_reg);
    elapsed = req.elapsed_time;
    limit   = 64'(req.step_limit);
    if (req.req_type == REQ_ADVANCE) begin
      if (elapsed[63]) begin
        res.status = ST_NEG;
      end else if (elapsed > STORE_MAX - stored_time) begin
        res.status = ST_OVF;
      end else begin
        stored_time       = stored_time + elapsed;
        avail             = stored_time / period;
        granted           = (avail < limit) ? avail : limit;
        res.granted_steps = granted[LIMIT_W-1:0];
        res.backlog_steps = 63'(avail - granted);
        res.limit_reached = avail > limit;
        stored_time       = stored_time - granted * period;
      end
    end else begin
      res.discarded_time = 63'((stored_time / period) * period);
      stored_time        = stored_time - 64'(res.discarded_time);
    end
    res.remaining_time = stored_time[WIDE_W-1:0];
    return res;
  endfunction

  function automatic void check_field(string label, logic [63:0] exp_val, logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s expected %0h, actual %0h", $time, label, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Results are compared before requests are predicted, so a result taken at the
  // same edge as a new request is matched against the older transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      period_reg  = STEP_PERIOD_RST;
      stored_time = '0;
      step_reports_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (step_reports_due.size() == 0) begin
          $display("%0t: result expected none, actual %h", $time, out_data);
          mismatches++;
        end else begin
          want = step_reports_due.pop_front();
          check_field("granted_steps", want.granted_steps, out_data.granted_steps);
          check_field("backlog_steps", want.backlog_steps, out_data.backlog_steps);
          check_field("remaining_time", want.remaining_time, out_data.remaining_time);
          check_field("limit_reached", want.limit_reached, out_data.limit_reached);
          check_field("discarded_time", want.discarded_time, out_data.discarded_time);
          check_field("status", want.status, out_data.status);
        end
      end
      if (cfg_valid && cfg_ready) begin
        period_reg = cfg_data;
      end
      if (in_valid && !in_stall) begin
        step_reports_due.push_back(accumulate_request(in_data));
      end
    end
    results_owed <= step_reports_due.size();
  end

endmodule

[dv/tb_fixed_step_time_accumulator.sv]
`timescale 1ns / 1ps

module tb_fixed_step_time_accumulator;
  import fsta_pkg::*;

  localparam logic [63:0] TIME_TOP      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MIN       = 64'h8000_0000_0000_0000;
  localparam logic [31:0] LIMIT_TOP     = 32'hFFFF_FFFF;
  localparam int          IDLE_LIMIT    = 5000;
  localparam int          SETTLE_CYCLES = 80;
  localparam int          PHASE_ITEMS   = 90;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  fsta_in_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  fsta_out_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [PERIOD_W-1:0] cfg_data  = '0;

  int                  mismatches;
  int                  results_owed;
  int                  quiet_cycles = 0;
  bit                  calm = 1'b0;
  logic [PERIOD_W-1:0] period_now = STEP_PERIOD_RST;

  fixed_step_time_accumulator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  fsta_step_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic logic [63:0] pick_elapsed();
    logic [63:0] raw;
    logic [63:0] eff;
    int          r;
    raw = {$urandom, $urandom};
    eff = (period_now == '0) ? 64'd1 : 64'(period_now);
    r   = $urandom_range(0, 99);
    if (r < 8)  return {1'b1, raw[62:0]};
    if (r < 14) return {1'b0, raw[62:0]};
    if (r < 17) return TIME_TOP - 64'($urandom_range(0, 1000));
    if (r < 25) return {1'b0, raw[62:0]} >> $urandom_range(1, 62);
    return eff * 64'($urandom_range(0, 6)) + 64'($urandom_range(0, eff[31:0]));
  endfunction

  function automatic logic [31:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, 4);
    if (r < 45) return LIMIT_TOP;
    if (r < 55) return $urandom_range(0, 100);
    return $urandom;
  endfunction

  task automatic send_request(input req_t kind, input logic [63:0] elapsed,
                              input logic [31:0] limit);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_data.req_type      <= kind;
    in_data.elapsed_time  <= elapsed;
    in_data.step_limit    <= limit;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic write_period(input logic [31:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    period_now  = value;
  endtask

  // Result side back-pressure; out_stall always drops again between stalls.
  initial begin
    int n;
    forever begin
      n = pick_gap();
      if (n == 0) begin
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("fixed_step_time_accumulator: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [31:0] next_period;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset period: step limits, both error kinds, discards.
    send_request(REQ_ADVANCE, 64'd0, 32'd0);
    send_request(REQ_ADVANCE, 64'd50_000_005, 32'd2);
    send_request(REQ_ADVANCE, 64'd0, LIMIT_TOP);
    send_request(REQ_ADVANCE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
    send_request(REQ_ADVANCE, NEG_MIN, LIMIT_TOP);
    send_request(REQ_ADVANCE, TIME_TOP, 32'd1);
    send_request(REQ_ADVANCE, 64'd40_000_000, 32'd0);
    send_request(REQ_DISCARD, 64'hFFFF_FFFF_FFFF_FFFF, LIMIT_TOP);
    send_request(REQ_DISCARD, 64'd0, 32'd0);

    // Unit period lets the store be filled to its very top.
    write_period(32'd1);
    send_request(REQ_DISCARD, 64'd0, 32'd0);
    send_request(REQ_ADVANCE, TIME_TOP, 32'd0);
    send_request(REQ_ADVANCE, 64'd1, 32'd5);
    send_request(REQ_ADVANCE, 64'd0, LIMIT_TOP);
    send_request(REQ_DISCARD, 64'd0, 32'd0);
    send_request(REQ_ADVANCE, TIME_TOP, LIMIT_TOP);

    // A zero period has to behave like a period of one.
    write_period(32'd0);
    send_request(REQ_ADVANCE, 64'd10, 32'd3);
    send_request(REQ_DISCARD, 64'd0, 32'd0);

    write_period(LIMIT_TOP);
    send_request(REQ_ADVANCE, 64'hFFFF_FFFE, 32'd1);
    send_request(REQ_ADVANCE, 64'd1, 32'd1);
    send_request(REQ_ADVANCE, 64'h0000_0002_0000_0000, 32'd1);
    send_request(REQ_DISCARD, 64'd0, 32'd0);
    send_request(REQ_ADVANCE, TIME_TOP, LIMIT_TOP);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       next_period = STEP_PERIOD_RST;
        1:       next_period = 32'd1;
        2:       next_period = 32'd3;
        3:       next_period = LIMIT_TOP;
        4:       next_period = 32'd0;
        5:       next_period = $urandom_range(2, 5000);
        default: next_period = $urandom;
      endcase
      write_period(next_period);
      calm = (phase % 3 == 1);
      repeat (PHASE_ITEMS) begin
        send_request(($urandom_range(0, 3) == 0) ? REQ_DISCARD : REQ_ADVANCE,
                     pick_elapsed(), pick_limit());
      end
    end
    calm = 1'b0;

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("fixed_step_time_accumulator: match");
    end else begin
      $display("fixed_step_time_accumulator: mismatch");
    end
    $finish;
  end

endmodule
